// ===== sv/issc_pkg.sv =====
package issc_pkg;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FORCE = 2'd2;

  localparam logic [4:0] ADDR_RUN  = 5'h07;
  localparam logic [4:0] ADDR_PROG = 5'h0B;
  localparam logic [7:0] BASE_MASK = 8'hFE;

  localparam logic [1:0] ST_POWER   = 2'd0;
  localparam logic [1:0] ST_STARTED = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;

  localparam logic [1:0] LM_OFF  = 2'd0;
  localparam logic [1:0] LM_ON   = 2'd1;
  localparam logic [1:0] LM_SLOW = 2'd2;
  localparam logic [1:0] LM_PROG = 2'd3;

  localparam logic [1:0] REG_SLOW_TICKS  = 2'd0;
  localparam logic [1:0] REG_PROG_TICKS  = 2'd1;
  localparam logic [1:0] REG_PROG_CYCLES = 2'd2;
  localparam logic [1:0] REG_LED_ENABLE  = 2'd3;

  localparam logic [15:0] SLOW_TICKS_RST  = 16'd1000;
  localparam logic [15:0] PROG_TICKS_RST  = 16'd200;
  localparam logic [3:0]  PROG_CYCLES_RST = 4'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] frame_address;
    logic [7:0] frame_command;
    logic [1:0] forced_state;
    logic [7:0] forced_arena;
  } in_item_t;

  typedef struct packed {
    logic [1:0] run_state;
    logic [7:0] arena_code;
    logic       led_on;
    logic       changed;
    logic       restart_request;
  } out_item_t;

  typedef struct packed {
    logic [15:0] slow_blink_ticks;
    logic [15:0] program_blink_ticks;
    logic [3:0]  prog_blink_pairs;
    logic        led_enable;
  } cfg_t;

endpackage

// ===== sv/issc_apb_regs.sv =====
module issc_apb_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output issc_pkg::cfg_t      cfg
);

  issc_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_blink_ticks     <= issc_pkg::SLOW_TICKS_RST;
      cfg_r.program_blink_ticks  <= issc_pkg::PROG_TICKS_RST;
      cfg_r.prog_blink_pairs     <= issc_pkg::PROG_CYCLES_RST;
      cfg_r.led_enable           <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        issc_pkg::REG_SLOW_TICKS:  cfg_r.slow_blink_ticks     <= pwdata[15:0];
        issc_pkg::REG_PROG_TICKS:  cfg_r.program_blink_ticks  <= pwdata[15:0];
        issc_pkg::REG_PROG_CYCLES: cfg_r.prog_blink_pairs     <= pwdata[3:0];
        issc_pkg::REG_LED_ENABLE:  cfg_r.led_enable           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      issc_pkg::REG_SLOW_TICKS:  prdata = {16'd0, cfg_r.slow_blink_ticks};
      issc_pkg::REG_PROG_TICKS:  prdata = {16'd0, cfg_r.program_blink_ticks};
      issc_pkg::REG_PROG_CYCLES: prdata = {28'd0, cfg_r.prog_blink_pairs};
      issc_pkg::REG_LED_ENABLE:  prdata = {31'd0, cfg_r.led_enable};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/issc_state_unit.sv =====
module issc_state_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  issc_pkg::in_item_t  item,
  input  issc_pkg::cfg_t      cfg,
  output issc_pkg::out_item_t result
);

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic [1:0]             mode_r,   mode_nxt;
  logic [7:0]             arena_r,  arena_nxt;
  logic [1:0]             lmode_r,  lmode_nxt;
  logic                   level_r,  level_nxt;
  logic [TIMER_WIDTH-1:0] ticks_r,  ticks_nxt;
  logic [4:0]             toggles_r, toggles_nxt;

  logic [TIMER_WIDTH-1:0] ticks_inc;
  logic [7:0]             base;
  logic                   follow;
  logic                   changed;
  logic                   restart;

  assign base      = item.frame_command & issc_pkg::BASE_MASK;
  assign ticks_inc = (&ticks_r) ? ticks_r : ticks_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    arena_nxt   = arena_r;
    lmode_nxt   = lmode_r;
    level_nxt   = level_r;
    ticks_nxt   = ticks_r;
    toggles_nxt = toggles_r;
    follow      = 1'b0;
    changed     = 1'b0;
    restart     = 1'b0;

    case (item.operation)
      issc_pkg::OP_TICK: begin
        if (cfg.led_enable) begin
          ticks_nxt = ticks_inc;
          case (lmode_r)
            issc_pkg::LM_OFF: level_nxt = 1'b0;
            issc_pkg::LM_ON:  level_nxt = 1'b1;
            issc_pkg::LM_SLOW: begin
              if (CW'(ticks_inc) >= CW'(cfg.slow_blink_ticks)) begin
                level_nxt = ~level_r;
                ticks_nxt = '0;
              end
            end
            default: begin
              if ((CW'(ticks_inc) >= CW'(cfg.program_blink_ticks)) &&
                  (toggles_r != 5'd0)) begin
                level_nxt   = ~level_r;
                toggles_nxt = toggles_r - 5'd1;
                ticks_nxt   = '0;
                follow      = (toggles_r == 5'd1);
              end
            end
          endcase
        end
      end
      issc_pkg::OP_FORCE: begin
        mode_nxt  = (item.forced_state == 2'd3) ? issc_pkg::ST_STOPPED : item.forced_state;
        arena_nxt = item.forced_arena;
        follow    = 1'b1;
      end
      issc_pkg::OP_FRAME: begin
        if (item.frame_address == issc_pkg::ADDR_PROG) begin
          if ((mode_r != issc_pkg::ST_STOPPED) && (base != arena_r)) begin
            arena_nxt   = base;
            mode_nxt    = issc_pkg::ST_POWER;
            changed     = 1'b1;
            lmode_nxt   = issc_pkg::LM_PROG;
            toggles_nxt = {cfg.prog_blink_pairs, 1'b0};
            ticks_nxt   = '0;
            if (cfg.led_enable) begin
              level_nxt = 1'b0;
            end
          end
        end else if ((item.frame_address == issc_pkg::ADDR_RUN) && (base == arena_r)) begin
          if (item.frame_command[0]) begin
            if (mode_r == issc_pkg::ST_STOPPED) begin
              restart     = 1'b1;
              changed     = 1'b1;
              mode_nxt    = issc_pkg::ST_POWER;
              lmode_nxt   = issc_pkg::LM_OFF;
              level_nxt   = 1'b0;
              ticks_nxt   = '0;
              toggles_nxt = 5'd0;
            end else if (mode_r == issc_pkg::ST_POWER) begin
              mode_nxt = issc_pkg::ST_STARTED;
              changed  = 1'b1;
              follow   = 1'b1;
            end
          end else if (mode_r != issc_pkg::ST_STOPPED) begin
            mode_nxt = issc_pkg::ST_STOPPED;
            changed  = 1'b1;
            follow   = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (follow) begin
      toggles_nxt = 5'd0;
      case (mode_nxt)
        issc_pkg::ST_STARTED: begin
          lmode_nxt = issc_pkg::LM_ON;
          if (cfg.led_enable) begin
            level_nxt = 1'b1;
          end
        end
        issc_pkg::ST_STOPPED: begin
          lmode_nxt = issc_pkg::LM_SLOW;
          ticks_nxt = '0;
          if (cfg.led_enable) begin
            level_nxt = 1'b0;
          end
        end
        default: begin
          lmode_nxt = issc_pkg::LM_OFF;
          if (cfg.led_enable) begin
            level_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= issc_pkg::ST_POWER;
      arena_r   <= 8'd0;
      lmode_r   <= issc_pkg::LM_OFF;
      level_r   <= 1'b0;
      ticks_r   <= '0;
      toggles_r <= 5'd0;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      arena_r   <= arena_nxt;
      lmode_r   <= lmode_nxt;
      level_r   <= level_nxt;
      ticks_r   <= ticks_nxt;
      toggles_r <= toggles_nxt;
    end
  end

  assign result.run_state       = mode_nxt;
  assign result.arena_code      = arena_nxt;
  assign result.led_on          = cfg.led_enable & level_nxt;
  assign result.changed         = changed;
  assign result.restart_request = restart;

endmodule

// ===== sv/ir_start_stop_controller_top.sv =====
// Path: an accepted transaction waits in the input register; its result is registered
// into the output register once that is empty or being read, and shown on out_data.
// Throughput: one transaction per cycle; while a result waits, the input register takes
// one more transaction and then the input stalls until the result is taken.
// Reset: rst_n is synchronous and active low; it empties both registers and restores
// the controller state and the configuration registers to their defaults.
module ir_start_stop_controller_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  issc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output issc_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  issc_pkg::cfg_t      cfg;
  issc_pkg::in_item_t  item_r;
  issc_pkg::out_item_t result;
  issc_pkg::out_item_t out_r;
  logic                item_valid_r;
  logic                out_valid_r;
  logic                advance;

  assign cfg_pready = 1'b1;
  assign advance    = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !item_valid_r || advance;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  issc_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  issc_state_unit #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

endmodule

// ===== sv/issc_checker.sv =====
module issc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input issc_pkg::out_item_t out_data
);

  a_restart_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.restart_request |-> out_data.changed)
    else $error("Restart request reported without a change.");

  a_restart_power_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.restart_request |-> out_data.run_state == issc_pkg::ST_POWER)
    else $error("Restart request reported outside the power-on state.");

  a_restart_led_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.restart_request |-> !out_data.led_on)
    else $error("Restart request reported with the LED lit.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction was dropped or changed.");

endmodule

bind ir_start_stop_controller_top issc_checker u_issc_checker (.*);
